// ===== hdl/indexed_min_heap_macros.svh =====
// Assertion macros for the indexed min-heap. Each expects clk and rst_n in scope.
`ifndef INDEXED_MIN_HEAP_MACROS_SVH
`define INDEXED_MIN_HEAP_MACROS_SVH
`ifndef SYNTH
`define IMH_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define IMH_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define IMH_ASSERT_SAME(label, ante, cons, msg)
`define IMH_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// ===== hdl/imh_pkg.sv =====
`default_nettype none
package imh_pkg;
  localparam int DEF_CAPACITY  = 64;
  localparam int DEF_PRIO_BITS = 16;
  localparam int KEY_SPACE     = 64;
  localparam int KEY_W         = 6;
  localparam int PORT_PRIO_W   = 16;
  localparam int MAXE_W        = 7;
  localparam logic [MAXE_W-1:0] MAXE_RESET = 7'd64;

  typedef logic [KEY_W-1:0] key_t;
  typedef logic [PORT_PRIO_W-1:0] port_prio_t;

  typedef enum logic [1:0] {
    REQ_PUSH   = 2'd0,
    REQ_POP    = 2'd1,
    REQ_CHANGE = 2'd2,
    REQ_DELETE = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_NO_KEY = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE, S_LOOKUP, S_TAKE, S_LAST, S_UP_ISSUE, S_UP_CMP, S_DN_ISSUE,
    S_DN_RL, S_DN_RR, S_DN_CMP, S_WRITE, S_FIN, S_HEAD
  } state_t;
endpackage
`default_nettype wire

// ===== hdl/imh_req_if.sv =====
`default_nettype none
interface imh_req_if;
  import imh_pkg::*;
  logic  valid;
  logic  ready;
  req_t  req_type;
  key_t  entry_key;
  port_prio_t entry_priority;
  modport source (output valid, req_type, entry_key, entry_priority, input ready);
  modport sink   (input valid, req_type, entry_key, entry_priority, output ready);
endinterface
`default_nettype wire

// ===== hdl/imh_rsp_if.sv =====
`default_nettype none
interface imh_rsp_if;
  import imh_pkg::*;
  logic       valid;
  logic       ready;
  status_t    status;
  key_t       removed_key;
  port_prio_t removed_priority;
  logic       head_valid;
  key_t       head_key;
  port_prio_t head_priority;
  logic [6:0] entry_count;
  logic [5:0] final_position;
  modport source (output valid, status, removed_key, removed_priority, head_valid,
                  head_key, head_priority, entry_count, final_position, input ready);
  modport sink   (input valid, status, removed_key, removed_priority, head_valid,
                  head_key, head_priority, entry_count, final_position, output ready);
endinterface
`default_nettype wire

// ===== hdl/indexed_min_heap.sv =====
// Indexed binary min-heap of (key, priority) words with a key-to-slot map. Requests on in_ch
// are push, pop of the minimum, change of priority and delete by key; each gives one result
// word on out_ch. One request is in work at a time: in_ch.ready is high only while idle, and
// a result waiting on out_ch does not block the next request until its own result is due.
// The heap slots and the key map sit in single-port-read memories, so the sift runs one slot
// read per cycle: per level, moving up has an issue and a compare state, and moving down an
// issue, a left-child read, a right-child read if that child exists and a compare; around them
// run accept, lookup, removal, write-back and head read, and a result waits in S_FIN until
// out_ch is free. max_entries is at byte address 0 of the cfg port and resets to 64.
`default_nettype none
`include "indexed_min_heap_macros.svh"
module indexed_min_heap #(
  parameter int CAPACITY      = imh_pkg::DEF_CAPACITY,
  parameter int PRIORITY_BITS = imh_pkg::DEF_PRIO_BITS
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  imh_req_if.sink          in_ch,
  imh_rsp_if.source        out_ch,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  import imh_pkg::*;

  localparam int SLOT_W = $clog2(CAPACITY);
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int PB     = PRIORITY_BITS;

  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [PB-1:0]     prio_t;

  key_t  slot_key_mem [CAPACITY];
  prio_t slot_pri_mem [CAPACITY];
  slot_t key_slot_mem [KEY_SPACE];

  state_t state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [KEY_SPACE-1:0] present_r, present_nxt;
  logic [MAXE_W-1:0] max_r;
  logic out_valid_r, out_valid_nxt;

  req_t    req_r, req_nxt;
  key_t    key_r, key_nxt;
  prio_t   cur_pri_r, cur_pri_nxt;
  key_t    cur_key_r, cur_key_nxt;
  slot_t   pos_r, pos_nxt;
  slot_t   chpos_r, chpos_nxt;
  key_t    chd_key_r, chd_key_nxt;
  prio_t   chd_pri_r, chd_pri_nxt;
  logic    settle_r, settle_nxt, moved_r, moved_nxt;
  status_t status_r, status_nxt;
  key_t    rm_key_r, rm_key_nxt;
  prio_t   rm_pri_r, rm_pri_nxt;
  slot_t   fpos_r, fpos_nxt;

  status_t    o_status_r, o_status_nxt;
  key_t       o_rm_key_r, o_rm_key_nxt;
  port_prio_t o_rm_pri_r, o_rm_pri_nxt;
  logic       o_hv_r, o_hv_nxt;
  key_t       o_hk_r, o_hk_nxt;
  port_prio_t o_hp_r, o_hp_nxt;
  logic [6:0] o_cnt_r, o_cnt_nxt;
  logic [5:0] o_fpos_r, o_fpos_nxt;

  slot_t rd_addr;
  key_t  rd_key_r;
  prio_t rd_pri_r;
  slot_t ks_rdata_r;
  logic  slot_we;
  slot_t slot_waddr;
  key_t  slot_wkey;
  prio_t slot_wpri;
  logic  ks_we;
  key_t  ks_waddr;
  slot_t ks_wdata;

  logic accept;
  logic out_free;
  logic cfg_wr;
  logic [SLOT_W+1:0] left_idx;
  slot_t parent_idx;
  logic  full;

  assign accept     = in_ch.valid && in_ch.ready;
  assign out_free   = !out_valid_r || out_ch.ready;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign left_idx   = {1'b0, pos_r, 1'b1};
  assign parent_idx = slot_t'((pos_r - slot_t'(1)) >> 1);
  assign full       = (32'(count_r) >= 32'(max_r)) || (32'(count_r) >= CAPACITY);

  assign in_ch.ready = (state_r == S_IDLE);
  assign cfg_pready  = 1'b1;
  assign cfg_prdata  = (cfg_paddr[2] == 1'b0) ? {25'd0, max_r} : 32'd0;

  assign out_ch.valid            = out_valid_r;
  assign out_ch.status           = o_status_r;
  assign out_ch.removed_key      = o_rm_key_r;
  assign out_ch.removed_priority = o_rm_pri_r;
  assign out_ch.head_valid       = o_hv_r;
  assign out_ch.head_key         = o_hk_r;
  assign out_ch.head_priority    = o_hp_r;
  assign out_ch.entry_count      = o_cnt_r;
  assign out_ch.final_position   = o_fpos_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (accept) state_nxt = S_LOOKUP;
      S_LOOKUP: begin
        if (req_r == REQ_PUSH && !present_r[key_r]) begin
          state_nxt = full ? S_FIN : S_UP_ISSUE;
        end else if (count_r == '0) begin
          state_nxt = S_FIN;
        end else if (req_r == REQ_POP) begin
          state_nxt = S_TAKE;
        end else if (!present_r[key_r] || 32'(ks_rdata_r) >= 32'(count_r)) begin
          state_nxt = S_FIN;
        end else if (req_r == REQ_DELETE) begin
          state_nxt = S_TAKE;
        end else begin
          state_nxt = S_UP_ISSUE;
        end
      end
      S_TAKE: begin
        if (32'(pos_r) == 32'(count_r) - 1) state_nxt = S_FIN;
        else state_nxt = S_LAST;
      end
      S_LAST: state_nxt = S_UP_ISSUE;
      S_UP_ISSUE: begin
        if (pos_r != '0) state_nxt = S_UP_CMP;
        else if (settle_r && !moved_r) state_nxt = S_DN_ISSUE;
        else state_nxt = S_WRITE;
      end
      S_UP_CMP: begin
        if (cur_pri_r < rd_pri_r) state_nxt = S_UP_ISSUE;
        else if (settle_r && !moved_r) state_nxt = S_DN_ISSUE;
        else state_nxt = S_WRITE;
      end
      S_DN_ISSUE: begin
        if (32'(left_idx) >= 32'(count_r)) state_nxt = S_WRITE;
        else state_nxt = S_DN_RL;
      end
      S_DN_RL: begin
        if (32'(left_idx) + 1 < 32'(count_r)) state_nxt = S_DN_RR;
        else state_nxt = S_DN_CMP;
      end
      S_DN_RR:  state_nxt = S_DN_CMP;
      S_DN_CMP: state_nxt = (cur_pri_r > chd_pri_r) ? S_DN_ISSUE : S_WRITE;
      S_WRITE:  state_nxt = S_FIN;
      S_FIN:    if (out_free) state_nxt = S_HEAD;
      S_HEAD:   state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    count_nxt     = count_r;
    present_nxt   = present_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    req_nxt       = req_r;
    key_nxt       = key_r;
    cur_pri_nxt   = cur_pri_r;
    cur_key_nxt   = cur_key_r;
    pos_nxt       = pos_r;
    chpos_nxt     = chpos_r;
    chd_key_nxt   = chd_key_r;
    chd_pri_nxt   = chd_pri_r;
    settle_nxt    = settle_r;
    moved_nxt     = moved_r;
    status_nxt    = status_r;
    rm_key_nxt    = rm_key_r;
    rm_pri_nxt    = rm_pri_r;
    fpos_nxt      = fpos_r;
    o_status_nxt  = o_status_r;
    o_rm_key_nxt  = o_rm_key_r;
    o_rm_pri_nxt  = o_rm_pri_r;
    o_hv_nxt      = o_hv_r;
    o_hk_nxt      = o_hk_r;
    o_hp_nxt      = o_hp_r;
    o_cnt_nxt     = o_cnt_r;
    o_fpos_nxt    = o_fpos_r;
    rd_addr       = pos_r;
    slot_we       = 1'b0;
    slot_waddr    = pos_r;
    slot_wkey     = cur_key_r;
    slot_wpri     = cur_pri_r;
    ks_we         = 1'b0;
    ks_waddr      = cur_key_r;
    ks_wdata      = pos_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          req_nxt     = in_ch.req_type;
          key_nxt     = in_ch.entry_key;
          cur_key_nxt = in_ch.entry_key;
          cur_pri_nxt = PB'(in_ch.entry_priority);
          status_nxt  = ST_OK;
          rm_key_nxt  = '0;
          rm_pri_nxt  = '0;
          fpos_nxt    = '0;
          settle_nxt  = 1'b1;
          moved_nxt   = 1'b0;
        end
      end
      S_LOOKUP: begin
        if (req_r == REQ_PUSH && !present_r[key_r]) begin
          if (full) begin
            status_nxt = ST_FULL;
          end else begin
            pos_nxt             = slot_t'(count_r);
            count_nxt           = count_r + CNT_W'(1);
            present_nxt[key_r]  = 1'b1;
            settle_nxt          = 1'b0;
          end
        end else if (count_r == '0) begin
          status_nxt = ST_EMPTY;
        end else if (req_r == REQ_POP) begin
          pos_nxt = '0;
          rd_addr = '0;
        end else if (!present_r[key_r] || 32'(ks_rdata_r) >= 32'(count_r)) begin
          status_nxt = ST_NO_KEY;
        end else begin
          pos_nxt = ks_rdata_r;
          rd_addr = ks_rdata_r;
        end
      end
      S_TAKE: begin
        rm_key_nxt            = rd_key_r;
        rm_pri_nxt            = rd_pri_r;
        present_nxt[rd_key_r] = 1'b0;
        count_nxt             = count_r - CNT_W'(1);
        rd_addr               = slot_t'(count_r - CNT_W'(1));
      end
      S_LAST: begin
        cur_key_nxt = rd_key_r;
        cur_pri_nxt = rd_pri_r;
      end
      S_UP_ISSUE: begin
        rd_addr   = parent_idx;
        chpos_nxt = parent_idx;
      end
      S_UP_CMP: begin
        if (cur_pri_r < rd_pri_r) begin
          slot_we   = 1'b1;
          slot_wkey = rd_key_r;
          slot_wpri = rd_pri_r;
          ks_we     = 1'b1;
          ks_waddr  = rd_key_r;
          pos_nxt   = chpos_r;
          moved_nxt = 1'b1;
        end
      end
      S_DN_ISSUE: rd_addr = slot_t'(left_idx);
      S_DN_RL: begin
        chd_key_nxt = rd_key_r;
        chd_pri_nxt = rd_pri_r;
        chpos_nxt   = slot_t'(left_idx);
        rd_addr     = slot_t'(left_idx + 1'b1);
      end
      S_DN_RR: begin
        if (chd_pri_r > rd_pri_r) begin
          chd_key_nxt = rd_key_r;
          chd_pri_nxt = rd_pri_r;
          chpos_nxt   = slot_t'(left_idx + 1'b1);
        end
      end
      S_DN_CMP: begin
        if (cur_pri_r > chd_pri_r) begin
          slot_we   = 1'b1;
          slot_wkey = chd_key_r;
          slot_wpri = chd_pri_r;
          ks_we     = 1'b1;
          ks_waddr  = chd_key_r;
          pos_nxt   = chpos_r;
        end
      end
      S_WRITE: begin
        slot_we = 1'b1;
        ks_we   = 1'b1;
        if (req_r == REQ_PUSH || req_r == REQ_CHANGE) fpos_nxt = pos_r;
      end
      S_FIN: rd_addr = '0;
      S_HEAD: begin
        out_valid_nxt = 1'b1;
        o_status_nxt  = status_r;
        o_rm_key_nxt  = rm_key_r;
        o_rm_pri_nxt  = PORT_PRIO_W'(rm_pri_r);
        o_hv_nxt      = (count_r != '0);
        o_hk_nxt      = (count_r != '0) ? rd_key_r : '0;
        o_hp_nxt      = (count_r != '0) ? PORT_PRIO_W'(rd_pri_r) : '0;
        o_cnt_nxt     = 7'(count_r);
        o_fpos_nxt    = 6'(fpos_r);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      present_r   <= '0;
      max_r       <= MAXE_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      present_r   <= present_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr && cfg_paddr[2] == 1'b0) max_r <= cfg_pwdata[MAXE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    key_r      <= key_nxt;
    cur_pri_r  <= cur_pri_nxt;
    cur_key_r  <= cur_key_nxt;
    pos_r      <= pos_nxt;
    chpos_r    <= chpos_nxt;
    chd_key_r  <= chd_key_nxt;
    chd_pri_r  <= chd_pri_nxt;
    settle_r   <= settle_nxt;
    moved_r    <= moved_nxt;
    status_r   <= status_nxt;
    rm_key_r   <= rm_key_nxt;
    rm_pri_r   <= rm_pri_nxt;
    fpos_r     <= fpos_nxt;
    o_status_r <= o_status_nxt;
    o_rm_key_r <= o_rm_key_nxt;
    o_rm_pri_r <= o_rm_pri_nxt;
    o_hv_r     <= o_hv_nxt;
    o_hk_r     <= o_hk_nxt;
    o_hp_r     <= o_hp_nxt;
    o_cnt_r    <= o_cnt_nxt;
    o_fpos_r   <= o_fpos_nxt;
  end

  always_ff @(posedge clk) begin
    if (slot_we) begin
      slot_key_mem[slot_waddr] <= slot_wkey;
      slot_pri_mem[slot_waddr] <= slot_wpri;
    end
    rd_key_r <= slot_key_mem[rd_addr];
    rd_pri_r <= slot_pri_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (ks_we) key_slot_mem[ks_waddr] <= ks_wdata;
    if (accept) ks_rdata_r <= key_slot_mem[in_ch.entry_key];
  end

  `IMH_ASSERT_NEXT(a_busy_after_accept, accept, state_r != S_IDLE, "accept left block idle")
  `IMH_ASSERT_SAME(a_count_bound, 1'b1, 32'(count_r) <= CAPACITY, "count beyond capacity")
  `IMH_ASSERT_SAME(a_count_map, 1'b1, 32'(count_r) == $countones(present_r),
                   "count and key map disagree")
  `IMH_ASSERT_SAME(a_head_flag, out_valid_r, o_hv_r == (o_cnt_r != 7'd0),
                   "head flag and count disagree")
endmodule
`default_nettype wire

// ===== tb/sv/indexed_min_heap_tb.sv =====
`timescale 1ns / 1ps
module indexed_min_heap_tb;
  import imh_pkg::*;

  localparam logic [2:0] ADDR_MAX_ENTRIES = 3'd0;
  localparam int DRAIN_CYCLES = 40;

  typedef struct {
    status_t    status;
    key_t       removed_key;
    port_prio_t removed_priority;
    logic       head_valid;
    key_t       head_key;
    port_prio_t head_priority;
    logic [6:0] entry_count;
    logic [5:0] final_position;
  } heap_result_t;

  logic clk;
  logic rst_n;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  imh_req_if req_ch();
  imh_rsp_if rsp_ch();

  indexed_min_heap u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(req_ch),
    .out_ch(rsp_ch),
    .cfg_psel(cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr),
    .cfg_pwdata(cfg_pwdata),
    .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  // heap mirror
  key_t       heap_key [DEF_CAPACITY];
  port_prio_t heap_pri [DEF_CAPACITY];
  int         key_pos  [KEY_SPACE];
  bit         key_held [KEY_SPACE];
  int         held;
  int         limit_val;

  heap_result_t pending_results[$];
  int errors;
  int tx_idle_pct;
  int rx_idle_pct;
  int hold_cycles;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic void swap_slots(int a, int b);
    key_t k;
    port_prio_t p;
    k = heap_key[a];
    p = heap_pri[a];
    heap_key[a] = heap_key[b];
    heap_pri[a] = heap_pri[b];
    heap_key[b] = k;
    heap_pri[b] = p;
    key_pos[heap_key[a]] = a;
    key_pos[heap_key[b]] = b;
  endfunction

  function automatic int sift_up(int p);
    int up;
    while (p > 0) begin
      up = (p - 1) / 2;
      if (heap_pri[p] < heap_pri[up]) begin
        swap_slots(p, up);
        p = up;
      end else begin
        break;
      end
    end
    return p;
  endfunction

  function automatic int sift_down(int p);
    int l;
    int c;
    forever begin
      l = 2 * p + 1;
      if (l >= held) break;
      c = l;
      if (l + 1 < held && heap_pri[l] > heap_pri[l + 1]) c = l + 1;
      if (heap_pri[p] > heap_pri[c]) begin
        swap_slots(p, c);
        p = c;
      end else begin
        break;
      end
    end
    return p;
  endfunction

  function automatic int resettle(int p);
    int q;
    q = sift_up(p);
    if (q == p) q = sift_down(p);
    return q;
  endfunction

  function automatic void remove_slot(int p);
    int unused;
    key_held[heap_key[p]] = 1'b0;
    held--;
    if (p != held) begin
      heap_key[p] = heap_key[held];
      heap_pri[p] = heap_pri[held];
      key_pos[heap_key[p]] = p;
      unused = resettle(p);
    end
  endfunction

  function automatic heap_result_t predict_request(req_t req, key_t key, port_prio_t pr);
    heap_result_t r;
    int cap;
    int p;
    cap = limit_val < DEF_CAPACITY ? limit_val : DEF_CAPACITY;
    r.status = ST_OK;
    r.removed_key = '0;
    r.removed_priority = '0;
    r.final_position = '0;
    if (req == REQ_PUSH && !key_held[key]) begin
      if (held >= cap) begin
        r.status = ST_FULL;
      end else begin
        p = held;
        heap_key[p] = key;
        heap_pri[p] = pr;
        key_pos[key] = p;
        key_held[key] = 1'b1;
        held++;
        r.final_position = 6'(sift_up(p));
      end
    end else if (req == REQ_PUSH || req == REQ_CHANGE) begin
      if (held == 0) r.status = ST_EMPTY;
      else if (!key_held[key] || key_pos[key] >= held) r.status = ST_NO_KEY;
      else begin
        p = key_pos[key];
        heap_pri[p] = pr;
        r.final_position = 6'(resettle(p));
      end
    end else if (req == REQ_POP) begin
      if (held == 0) r.status = ST_EMPTY;
      else begin
        r.removed_key = heap_key[0];
        r.removed_priority = heap_pri[0];
        remove_slot(0);
      end
    end else begin
      if (held == 0) r.status = ST_EMPTY;
      else if (!key_held[key] || key_pos[key] >= held) r.status = ST_NO_KEY;
      else begin
        p = key_pos[key];
        r.removed_key = heap_key[p];
        r.removed_priority = heap_pri[p];
        remove_slot(p);
      end
    end
    r.head_valid = held > 0;
    r.head_key = held > 0 ? heap_key[0] : '0;
    r.head_priority = held > 0 ? heap_pri[0] : '0;
    r.entry_count = 7'(held);
    return r;
  endfunction

  task automatic report_mismatch(string field, longint got, longint want);
    $display("%0t: %s got %0d expected %0d", $realtime, field, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    heap_result_t w;
    if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected word, count", rsp_ch.entry_count, 0);
      end else begin
        w = pending_results.pop_front();
        if (rsp_ch.status !== w.status) report_mismatch("status", rsp_ch.status, w.status);
        if (rsp_ch.removed_key !== w.removed_key)
          report_mismatch("removed_key", rsp_ch.removed_key, w.removed_key);
        if (rsp_ch.removed_priority !== w.removed_priority)
          report_mismatch("removed_priority", rsp_ch.removed_priority, w.removed_priority);
        if (rsp_ch.head_valid !== w.head_valid)
          report_mismatch("head_valid", rsp_ch.head_valid, w.head_valid);
        if (rsp_ch.head_key !== w.head_key)
          report_mismatch("head_key", rsp_ch.head_key, w.head_key);
        if (rsp_ch.head_priority !== w.head_priority)
          report_mismatch("head_priority", rsp_ch.head_priority, w.head_priority);
        if (rsp_ch.entry_count !== w.entry_count)
          report_mismatch("entry_count", rsp_ch.entry_count, w.entry_count);
        if (rsp_ch.final_position !== w.final_position)
          report_mismatch("final_position", rsp_ch.final_position, w.final_position);
      end
    end
  end

  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      rsp_ch.ready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      rsp_ch.ready <= $urandom_range(99) >= rx_idle_pct;
    end
  end

  task automatic send_word(req_t req, key_t key, port_prio_t pr);
    while ($urandom_range(99) < tx_idle_pct) begin
      @(negedge clk);
      req_ch.valid <= 1'b0;
    end
    @(negedge clk);
    req_ch.valid <= 1'b1;
    req_ch.req_type <= req;
    req_ch.entry_key <= key;
    req_ch.entry_priority <= pr;
    do @(posedge clk); while (!req_ch.ready);
    pending_results.push_back(predict_request(req, key, pr));
  endtask

  task automatic wait_idle();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_max_entries(int value);
    wait_idle();
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= ADDR_MAX_ENTRIES;
    cfg_pwdata <= 32'(value);
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    limit_val = value & 7'h7f;
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  task automatic random_word();
    int r;
    req_t req;
    key_t key;
    port_prio_t pr;
    r = $urandom_range(99);
    if (held < 8) req = r < 70 ? REQ_PUSH : req_t'($urandom_range(3));
    else if (held > 40) req = r < 20 ? REQ_PUSH : req_t'($urandom_range(3));
    else req = r < 40 ? REQ_PUSH : req_t'($urandom_range(3));
    if (held > 0 && req != REQ_PUSH && $urandom_range(99) < 75)
      key = heap_key[$urandom_range(held - 1)];
    else
      key = key_t'($urandom_range(63));
    case ($urandom_range(3))
      0: pr = port_prio_t'($urandom_range(7));
      1: pr = $urandom_range(1) ? 16'hffff : 16'h0000;
      default: pr = port_prio_t'($urandom_range(16'hffff));
    endcase
    send_word(req, key, pr);
  endtask

  task automatic test_directed();
    send_word(REQ_POP, 6'd0, 16'd0);
    send_word(REQ_CHANGE, 6'd5, 16'd1);
    send_word(REQ_DELETE, 6'd5, 16'd1);
    send_word(REQ_PUSH, 6'd63, 16'hffff);
    send_word(REQ_PUSH, 6'd0, 16'h0000);
    send_word(REQ_PUSH, 6'd21, 16'h0000);
    send_word(REQ_PUSH, 6'd42, 16'h8000);
    send_word(REQ_PUSH, 6'd42, 16'h0001);
    send_word(REQ_CHANGE, 6'd63, 16'h0000);
    send_word(REQ_CHANGE, 6'd7, 16'h1234);
    send_word(REQ_DELETE, 6'd7, 16'h0);
    send_word(REQ_DELETE, 6'd0, 16'h0);
    send_word(REQ_POP, 6'd0, 16'h0);
    write_max_entries(2);
    send_word(REQ_PUSH, 6'd10, 16'h0005);
    send_word(REQ_PUSH, 6'd11, 16'h0005);
    write_max_entries(0);
    send_word(REQ_PUSH, 6'd12, 16'h0001);
    send_word(REQ_PUSH, 6'd42, 16'hfffe);
    send_word(REQ_POP, 6'd0, 16'h0);
    send_word(REQ_DELETE, 6'd21, 16'h0);
    send_word(REQ_POP, 6'd0, 16'h0);
    send_word(REQ_POP, 6'd0, 16'h0);
    send_word(REQ_POP, 6'd0, 16'h0);
    write_max_entries(64);
  endtask

  task automatic test_random(int limit, int count);
    write_max_entries(limit);
    repeat (count) random_word();
  endtask

  task automatic test_backpressure();
    int n;
    wait_idle();
    hold_cycles = 300;
    for (n = 0; n < 12; n++) random_word();
    wait_idle();
    for (n = 0; n < 20; n++) random_word();
  endtask

  initial begin
    errors = 0;
    held = 0;
    limit_val = MAXE_RESET;
    hold_cycles = 0;
    tx_idle_pct = 15;
    rx_idle_pct = 48;
    for (int i = 0; i < KEY_SPACE; i++) key_held[i] = 1'b0;
    rst_n = 1'b0;
    req_ch.valid = 1'b0;
    req_ch.req_type = REQ_PUSH;
    req_ch.entry_key = '0;
    req_ch.entry_priority = '0;
    rsp_ch.ready = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_random(64, 350);
    test_random(7, 150);
    test_backpressure();
    tx_idle_pct = 48;
    rx_idle_pct = 15;
    test_random(1, 100);
    test_random(127, 350);
    test_random(33, 200);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_random(64, 350);
    test_random(0, 60);
    test_random(64, 200);

    wait_idle();
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule

// ===== indexed_min_heap.f =====
+incdir+hdl
hdl/imh_pkg.sv
hdl/imh_req_if.sv
hdl/imh_rsp_if.sv
hdl/indexed_min_heap.sv
tb/sv/indexed_min_heap_tb.sv
